@@ hw/rtl/signal_pending_mask_controller_macros.svh @@
// Assertion helpers for the RTL of the pending-and-mask unit.
`ifndef SIGNAL_PENDING_MASK_CONTROLLER_MACROS_SVH
`define SIGNAL_PENDING_MASK_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define SPMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define SPMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SPMC_ASSERT(lbl, prop, msg)
`define SPMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/spmc_pkg.sv @@
package spmc_pkg;

  localparam int unsigned NumSignals        = 64;
  localparam int unsigned QueueSlots        = 32;
  localparam int unsigned FirstQueuedSignal = 32;

  localparam int unsigned SigW  = 7;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned CntW  = 6;
  localparam int unsigned MaskW = 64;
  localparam int unsigned PAddrW = 4;
  localparam int unsigned PDataW = 64;

  // Signal numbers with special treatment.
  localparam logic [SigW-1:0] SigInt   = 7'd2;
  localparam logic [SigW-1:0] SigQuit  = 7'd3;
  localparam logic [SigW-1:0] SigKill  = 7'd9;
  localparam logic [SigW-1:0] SigTerm  = 7'd15;
  localparam logic [SigW-1:0] SigCont  = 7'd18;
  localparam logic [SigW-1:0] SigStop  = 7'd19;
  localparam logic [SigW-1:0] SigTstp  = 7'd20;
  localparam logic [SigW-1:0] SigTtin  = 7'd21;
  localparam logic [SigW-1:0] SigTtou  = 7'd22;
  localparam logic [SigW-1:0] SigUrg   = 7'd23;
  localparam logic [SigW-1:0] SigWinch = 7'd28;

  localparam logic [MaskW-1:0] AllSigs = {MaskW{1'b1}} >> (MaskW - NumSignals);
  localparam logic [MaskW-1:0] Unblockable =
      (64'd1 << (int'(SigKill) - 1)) | (64'd1 << (int'(SigStop) - 1));

  // Register byte addresses: bit 3 of the address selects the register.
  localparam logic RegIgnore  = 1'b0;
  localparam logic RegHandler = 1'b1;

  typedef enum logic [2:0] {
    ModePostThread = 3'd0,
    ModePostShared = 3'd1,
    ModeDequeue    = 3'd2,
    ModeBlock      = 3'd3,
    ModeUnblock    = 3'd4,
    ModeSetmask    = 3'd5
  } spmc_mode_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusNone    = 2'd2,
    StatusFull    = 2'd3
  } spmc_status_e;

  typedef enum logic [1:0] {
    EvtNone      = 2'd0,
    EvtStopped   = 2'd1,
    EvtContinued = 2'd2,
    EvtTerminate = 2'd3
  } spmc_event_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } spmc_state_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [CntW-1:0] data;
  } spmc_cnt_wr_t;

endpackage

@@ hw/rtl/spmc_cnt_ram.sv @@
module spmc_cnt_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [spmc_pkg::IdxW-1:0]     rd_addr_i,
  output logic [spmc_pkg::CntW-1:0]     rd_data_o,
  input  spmc_pkg::spmc_cnt_wr_t        wr_i
);
  import spmc_pkg::*;

  localparam int unsigned Depth = 2 ** IdxW;

  logic [CntW-1:0]  cnt_mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [CntW-1:0]  rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cnt_mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= cnt_mem[rd_addr_i];
    end
  end

  // An entry never written since reset reads as a zero count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ hw/rtl/spmc_cfg_regs.sv @@
module spmc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spmc_pkg::PAddrW-1:0] paddr,
  input  logic [spmc_pkg::PDataW-1:0] pwdata,
  output logic [spmc_pkg::PDataW-1:0] prdata,
  output logic                        pready,
  output logic [spmc_pkg::MaskW-1:0]  ignore_o,
  output logic [spmc_pkg::MaskW-1:0]  handler_o
);
  import spmc_pkg::*;

  logic [MaskW-1:0] ignore_q;
  logic [MaskW-1:0] handler_q;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_q  <= '0;
      handler_q <= '0;
    end else if (wr_en) begin
      if (reg_sel == RegHandler) begin
        handler_q <= pwdata;
      end else begin
        ignore_q <= pwdata;
      end
    end
  end

  // Address bits below bit 3 are not decoded.
  assign prdata    = (reg_sel == RegHandler) ? handler_q : ignore_q;
  assign ignore_o  = ignore_q;
  assign handler_o = handler_q;

endmodule

@@ hw/rtl/signal_pending_mask_controller.sv @@
// An accepted item and its count memory read are registered, then the write-back
// registers its result on the output, held back only while an earlier result is stalled.
// Items go through one at a time: the input stalls in the execute state until the item's
// instance count, read from memory at acceptance, has been written back.
// A new item is accepted while a finished result still waits on the output.
// Reset clears pending sets, blocked mask, total count and config registers;
// count memory entries read as zero until written, so no clearing pass runs.
module signal_pending_mask_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  mode_i,
  input  logic [spmc_pkg::SigW-1:0]   signal_number_i,
  input  logic [spmc_pkg::MaskW-1:0]  mask_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [spmc_pkg::SigW-1:0]   signal_out_o,
  output logic [1:0]                  event_res_o,
  output logic                        wake_o,
  output logic [spmc_pkg::MaskW-1:0]  prev_mask_o,
  output logic [spmc_pkg::MaskW-1:0]  pending_view_o,
  output logic                        deliverable_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spmc_pkg::PAddrW-1:0] paddr,
  input  logic [spmc_pkg::PDataW-1:0] pwdata,
  output logic [spmc_pkg::PDataW-1:0] prdata,
  output logic                        pready
);
  import spmc_pkg::*;

  `include "signal_pending_mask_controller_macros.svh"

  spmc_state_e      state_q, state_d;
  logic             accept;
  logic             exec_go;

  logic [MaskW-1:0] ignore_set;
  logic [MaskW-1:0] handler_set;

  // Item held between acceptance and write-back.
  spmc_mode_e       mode_q;
  logic [SigW-1:0]  sig_q;
  logic [MaskW-1:0] mw_q;
  logic             pick_nz_q;
  logic [IdxW-1:0]  pick_idx_q;

  logic [MaskW-1:0] thr_q, thr_d;
  logic [MaskW-1:0] shr_q, shr_d;
  logic [MaskW-1:0] blk_q, blk_d;
  logic [CntW-1:0]  total_q, total_d;

  logic             out_valid_q;
  spmc_status_e     status_q, status_d;
  logic [SigW-1:0]  sig_out_q, sig_out_d;
  spmc_event_e      evt_q, evt_d;
  logic             wake_q, wake_d;
  logic [MaskW-1:0] prev_mask_q;
  logic [MaskW-1:0] pv_q, pv_d;
  logic             dlv_q, dlv_d;

  logic [MaskW-1:0] cand;
  logic [IdxW-1:0]  pick_idx;
  logic [IdxW-1:0]  rd_addr;
  logic [CntW-1:0]  cnt;
  spmc_cnt_wr_t     wr_req, cnt_wr;

  logic             sig_ok;
  logic [IdxW-1:0]  post_idx;
  logic [MaskW-1:0] post_bit;
  logic [MaskW-1:0] pick_bit;
  logic             ignored;
  logic             replace;
  logic             term_sig;
  logic             dflt;

  spmc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ignore_o  (ignore_set),
    .handler_o (handler_set)
  );

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    exec_go    = 1'b0;
    case (state_q)
      StIdle: in_stall_o = 1'b0;
      StExec: exec_go = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- acceptance: pick and memory read ----------------
  assign cand = (thr_q | shr_q) & ~blk_q & ~mask_word_i & AllSigs;

  always_comb begin
    pick_idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_idx = IdxW'(i);
      end
    end
  end

  assign rd_addr = (mode_i == ModePostThread || mode_i == ModePostShared) ?
                   IdxW'(signal_number_i - 7'd1) : pick_idx;

  spmc_cnt_ram u_cnt_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (cnt),
    .wr_i      (cnt_wr)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= spmc_mode_e'(mode_i);
      sig_q      <= signal_number_i;
      mw_q       <= mask_word_i;
      pick_nz_q  <= |cand;
      pick_idx_q <= pick_idx;
    end
  end

  // ---------------- write-back ----------------
  assign sig_ok   = (sig_q != '0) && (sig_q <= SigW'(NumSignals));
  assign post_idx = IdxW'(sig_q - 7'd1);
  assign post_bit = MaskW'(1) << post_idx;
  assign pick_bit = MaskW'(1) << pick_idx_q;

  // SIGKILL and SIGSTOP ignore their disposition bits entirely.
  assign ignored = (sig_q != SigKill) && (sig_q != SigStop) &&
                   ((ignore_set[post_idx]) ||
                    (!handler_set[post_idx] && (sig_q == SigUrg || sig_q == SigWinch)));
  assign dflt    = (sig_q == SigKill) || (sig_q == SigStop) ||
                   !(ignore_set[post_idx] || handler_set[post_idx]);
  assign term_sig = (sig_q == SigTerm) || (sig_q == SigKill) ||
                    (sig_q == SigInt) || (sig_q == SigQuit);
  assign replace = (sig_q < SigW'(FirstQueuedSignal)) && (cnt != '0);

  always_comb begin
    thr_d     = thr_q;
    shr_d     = shr_q;
    blk_d     = blk_q;
    total_d   = total_q;
    status_d  = StatusOk;
    sig_out_d = '0;
    evt_d     = EvtNone;
    wake_d    = 1'b0;
    wr_req    = '0;
    case (mode_q)
      ModePostThread, ModePostShared: begin
        if (!sig_ok) begin
          status_d = StatusInvalid;
        end else if (!(ignored && sig_q != SigCont)) begin
          if (!replace && total_q >= CntW'(QueueSlots)) begin
            status_d = StatusFull;
          end else begin
            if (!replace) begin
              wr_req.en   = 1'b1;
              wr_req.addr = post_idx;
              wr_req.data = cnt + 6'd1;
              total_d     = total_q + 6'd1;
            end
            if (mode_q == ModePostShared) begin
              shr_d = shr_q | post_bit;
            end else begin
              thr_d = thr_q | post_bit;
            end
            if (sig_q == SigStop || sig_q == SigTstp || sig_q == SigTtin ||
                sig_q == SigTtou) begin
              evt_d = EvtStopped;
            end else if (sig_q == SigCont) begin
              evt_d = EvtContinued;
            end else if (term_sig && dflt) begin
              evt_d = EvtTerminate;
            end
            wake_d = 1'b1;
          end
        end
      end
      ModeDequeue: begin
        if (!pick_nz_q) begin
          status_d = StatusNone;
        end else begin
          sig_out_d = {1'b0, pick_idx_q} + 7'd1;
          if (cnt != '0) begin
            wr_req.en   = 1'b1;
            wr_req.addr = pick_idx_q;
            wr_req.data = cnt - 6'd1;
            if (total_q != '0) begin
              total_d = total_q - 6'd1;
            end
          end
          // The count ends at zero when it was one or already zero.
          if (cnt <= 6'd1) begin
            thr_d = thr_q & ~pick_bit;
            shr_d = shr_q & ~pick_bit;
          end
        end
      end
      ModeBlock:   blk_d = (blk_q | mw_q) & AllSigs & ~Unblockable;
      ModeUnblock: blk_d = (blk_q & ~mw_q) & AllSigs & ~Unblockable;
      ModeSetmask: blk_d = mw_q & AllSigs & ~Unblockable;
      default:     status_d = StatusInvalid;
    endcase
    pv_d  = thr_d | shr_d;
    dlv_d = |(pv_d & ~blk_d);
  end

  always_comb begin
    cnt_wr    = wr_req;
    cnt_wr.en = wr_req.en && exec_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      shr_q   <= '0;
      blk_q   <= '0;
      total_q <= '0;
    end else if (exec_go) begin
      thr_q   <= thr_d;
      shr_q   <= shr_d;
      blk_q   <= blk_d;
      total_q <= total_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      status_q    <= status_d;
      sig_out_q   <= sig_out_d;
      evt_q       <= evt_d;
      wake_q      <= wake_d;
      prev_mask_q <= blk_q;
      pv_q        <= pv_d;
      dlv_q       <= dlv_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign signal_out_o   = sig_out_q;
  assign event_res_o    = evt_q;
  assign wake_o         = wake_q;
  assign prev_mask_o    = prev_mask_q;
  assign pending_view_o = pv_q;
  assign deliverable_o  = dlv_q;

  // ---------------- checks ----------------
  `SPMC_ASSERT(a_accept_to_exec, accept |=> state_q == StExec, "accepted beat did not start")
  `SPMC_ASSERT(a_exec_loads_out, exec_go |=> out_valid_q, "finished item produced no result")
  `SPMC_ASSERT(a_total_bound, total_q <= CntW'(QueueSlots), "queue total over limit")
  `SPMC_ASSERT(a_unblockable, (blk_q & Unblockable) == '0, "KILL or STOP blocked")

endmodule

@@ verif/signal_pending_mask_controller_tb.sv @@
module signal_pending_mask_controller_tb;
  import spmc_pkg::*;

  // Reserved mode encodings, which the block must reject.
  localparam logic [2:0] ModeReservedLo = 3'd6;
  localparam logic [2:0] ModeReservedHi = 3'd7;
  localparam logic [MaskW-1:0] NoSigs = '0;
  localparam logic [MaskW-1:0] EverySig = '1;

  typedef struct {
    spmc_status_e    status;
    logic [SigW-1:0] signal_out;
    spmc_event_e     evt;
    logic            wake;
    logic [MaskW-1:0] prev_mask;
    logic [MaskW-1:0] pending_view;
    logic            deliverable;
  } sig_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [2:0]        mode_i = '0;
  logic [SigW-1:0]   signal_number_i = '0;
  logic [MaskW-1:0]  mask_word_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [SigW-1:0]   signal_out_o;
  logic [1:0]        event_res_o;
  logic              wake_o;
  logic [MaskW-1:0]  prev_mask_o;
  logic [MaskW-1:0]  pending_view_o;
  logic              deliverable_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PAddrW-1:0] paddr = '0;
  logic [PDataW-1:0] pwdata = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  // Mirror of the block's registers and state.
  logic [MaskW-1:0] ignore_reg = '0;
  logic [MaskW-1:0] handler_reg = '0;
  logic [MaskW-1:0] thread_pend = '0;
  logic [MaskW-1:0] shared_pend = '0;
  logic [MaskW-1:0] blocked = '0;
  logic [CntW-1:0]  inst_count [NumSignals];
  logic [CntW-1:0]  slots_used = '0;

  sig_result_t awaited_results [$];
  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  int unsigned max_gap = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;
  logic        stalling = 1'b0;

  logic [SigW-1:0] special_sigs [11] = '{SigInt, SigQuit, SigKill, SigTerm, SigCont, SigStop,
                                         SigTstp, SigTtin, SigTtou, SigUrg, SigWinch};

  signal_pending_mask_controller dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .signal_number_i(signal_number_i),
    .mask_word_i    (mask_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .signal_out_o   (signal_out_o),
    .event_res_o    (event_res_o),
    .wake_o         (wake_o),
    .prev_mask_o    (prev_mask_o),
    .pending_view_o (pending_view_o),
    .deliverable_o  (deliverable_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < NumSignals; k++) inst_count[k] = '0;
  end

  // Applies one item to the mirrored state and returns the result it should produce.
  function automatic sig_result_t next_signal_result(input logic [2:0] mode,
                                                     input logic [SigW-1:0] sig,
                                                     input logic [MaskW-1:0] mw);
    sig_result_t r;
    logic [MaskW-1:0] bit_m;
    logic [MaskW-1:0] cand;
    logic [MaskW-1:0] pv;
    logic [IdxW-1:0]  idx;
    logic             ign;
    logic             dflt;
    logic             reuse;
    int               lowest;
    r.status = StatusOk;
    r.signal_out = '0;
    r.evt = EvtNone;
    r.wake = 1'b0;
    r.prev_mask = blocked;
    case (mode)
      ModePostThread, ModePostShared: begin
        if (sig == 0 || sig > NumSignals) begin
          r.status = StatusInvalid;
        end else begin
          idx = IdxW'(sig - 1);
          bit_m = 64'd1 << idx;
          ign = (sig != SigKill && sig != SigStop) &&
                ((ignore_reg & bit_m) != 0 ||
                 ((handler_reg & bit_m) == 0 && (sig == SigUrg || sig == SigWinch)));
          dflt = sig == SigKill || sig == SigStop || ((ignore_reg | handler_reg) & bit_m) == 0;
          if (!ign || sig == SigCont) begin
            // Low signals hold one instance only, so a repeat needs no new slot.
            reuse = sig < FirstQueuedSignal && inst_count[idx] != 0;
            if (!reuse && slots_used >= QueueSlots) begin
              r.status = StatusFull;
            end else begin
              if (!reuse) begin
                inst_count[idx] = inst_count[idx] + 1'b1;
                slots_used = slots_used + 1'b1;
              end
              if (mode == ModePostShared) shared_pend = shared_pend | bit_m;
              else thread_pend = thread_pend | bit_m;
              if (sig == SigStop || sig == SigTstp || sig == SigTtin || sig == SigTtou)
                r.evt = EvtStopped;
              else if (sig == SigCont)
                r.evt = EvtContinued;
              else if ((sig == SigTerm || sig == SigKill || sig == SigInt || sig == SigQuit) && dflt)
                r.evt = EvtTerminate;
              r.wake = 1'b1;
            end
          end
        end
      end
      ModeDequeue: begin
        cand = (thread_pend | shared_pend) & ~blocked & ~mw & AllSigs;
        if (cand == 0) begin
          r.status = StatusNone;
        end else begin
          lowest = 0;
          while (!cand[lowest]) lowest++;
          idx = IdxW'(lowest);
          r.signal_out = SigW'(lowest + 1);
          if (inst_count[idx] != 0) begin
            inst_count[idx] = inst_count[idx] - 1'b1;
            if (slots_used != 0) slots_used = slots_used - 1'b1;
          end
          if (inst_count[idx] == 0) begin
            thread_pend[idx] = 1'b0;
            shared_pend[idx] = 1'b0;
          end
        end
      end
      ModeBlock:   blocked = (blocked | mw) & AllSigs & ~Unblockable;
      ModeUnblock: blocked = (blocked & ~mw) & AllSigs & ~Unblockable;
      ModeSetmask: blocked = mw & AllSigs & ~Unblockable;
      default:     r.status = StatusInvalid;
    endcase
    pv = thread_pend | shared_pend;
    r.pending_view = pv;
    r.deliverable = (pv & ~blocked) != 0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Valid and stall are stable from the falling edge up to the accepting rising edge.
  always @(negedge clk_i) begin
    sig_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no item outstanding");
        err_count++;
      end else begin
        e = awaited_results.pop_front();
        check_field("status", e.status, status_o);
        check_field("signal_out", e.signal_out, signal_out_o);
        check_field("event_res", e.evt, event_res_o);
        check_field("wake", e.wake, wake_o);
        check_field("prev_mask", e.prev_mask, prev_mask_o);
        check_field("pending_view", e.pending_view, pending_view_o);
        check_field("deliverable", e.deliverable, deliverable_o);
      end
    end
  end

  // The receiver stalls in runs of random length.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stalling = stall_pct != 0 && $urandom_range(0, 99) < stall_pct;
      stall_run = $urandom_range(1, 8);
    end
    stall_run--;
    out_stall_i <= stalling;
  end

  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_item(input logic [2:0] mode, input logic [SigW-1:0] sig,
                           input logic [MaskW-1:0] mw);
    int unsigned gap;
    if (max_gap != 0 && burst_left == 0) begin
      gap = $urandom_range(1, max_gap);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= mode;
    signal_number_i <= sig;
    mask_word_i <= mw;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    awaited_results.push_back(next_signal_result(mode, sig, mw));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [MaskW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == RegHandler) handler_reg = value;
    else ignore_reg = value;
  endtask

  task automatic set_dispositions(input logic [MaskW-1:0] ign, input logic [MaskW-1:0] hnd);
    wait_idle();
    write_reg(RegIgnore, ign);
    write_reg(RegHandler, hnd);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [MaskW-1:0] pick_mask();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return NoSigs;
    if (r == 1) return EverySig;
    if (r < 5) return rand64();
    return rand64() & rand64() & rand64();
  endfunction

  function automatic logic [SigW-1:0] pick_signal();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return special_sigs[$urandom_range(0, 10)];
    if (r < 70) return SigW'($urandom_range(FirstQueuedSignal, NumSignals));
    if (r < 95) return SigW'($urandom_range(1, FirstQueuedSignal - 1));
    return SigW'($urandom_range(0, 127));
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 46)
      send_item($urandom_range(0, 1) ? ModePostShared : ModePostThread, pick_signal(), rand64());
    else if (r < 76)
      send_item(ModeDequeue, SigW'($urandom_range(0, 127)),
                $urandom_range(0, 9) < 6 ? NoSigs : pick_mask());
    else if (r < 90)
      send_item(3'($urandom_range(ModeBlock, ModeSetmask)), SigW'($urandom_range(0, 127)),
                pick_mask());
    else
      send_item(3'($urandom_range(0, 7)), SigW'($urandom_range(0, 127)), rand64());
  endtask

  task automatic test_defaults();
    send_item(ModeDequeue, '0, NoSigs);
    send_item(ModePostThread, '0, NoSigs);
    send_item(ModePostThread, SigW'(NumSignals + 1), NoSigs);
    send_item(ModePostShared, '1, EverySig);
    send_item(ModeReservedLo, SigInt, EverySig);
    send_item(ModeReservedHi, SigInt, NoSigs);
    send_item(ModePostThread, SigUrg, NoSigs);
    send_item(ModePostShared, SigWinch, NoSigs);
    send_item(ModePostThread, SigInt, NoSigs);
    send_item(ModePostShared, SigKill, NoSigs);
    send_item(ModePostThread, SigStop, NoSigs);
    send_item(ModePostThread, SigTstp, NoSigs);
    send_item(ModePostShared, SigTtin, NoSigs);
    send_item(ModePostThread, SigTtou, NoSigs);
    send_item(ModePostShared, SigCont, NoSigs);
    send_item(ModePostShared, SigW'(NumSignals), NoSigs);
    send_item(ModePostThread, SigW'(1), NoSigs);
    // Kill and stop must stay deliverable under a full block.
    send_item(ModeSetmask, '0, EverySig);
    send_item(ModeDequeue, '0, NoSigs);
    send_item(ModeUnblock, '0, EverySig);
    send_item(ModeDequeue, '0, EverySig);
    send_item(ModeDequeue, '0, ~64'd1);
    send_item(ModeBlock, '0, 64'hFFFF_FFFF_0000_0000);
    repeat (12) send_item(ModeDequeue, '0, NoSigs);
    send_item(ModeSetmask, '0, NoSigs);
  endtask

  task automatic test_dispositions();
    set_dispositions(EverySig, NoSigs);
    send_item(ModePostThread, SigCont, NoSigs);
    send_item(ModePostThread, SigKill, NoSigs);
    send_item(ModePostShared, SigStop, NoSigs);
    send_item(ModePostThread, SigInt, NoSigs);
    send_item(ModePostShared, SigW'(40), NoSigs);
    set_dispositions(NoSigs, EverySig);
    send_item(ModePostThread, SigInt, NoSigs);
    send_item(ModePostShared, SigTerm, NoSigs);
    send_item(ModePostThread, SigUrg, NoSigs);
    send_item(ModePostShared, SigWinch, NoSigs);
    send_item(ModePostThread, SigKill, NoSigs);
    set_dispositions(EverySig, EverySig);
    send_item(ModePostThread, SigUrg, NoSigs);
    send_item(ModePostThread, SigQuit, NoSigs);
    send_item(ModePostShared, SigCont, NoSigs);
    // An ignore bit on kill has no effect; a handler bit alone un-ignores urgent data.
    set_dispositions(64'd1 << (SigKill - 1), 64'd1 << (SigUrg - 1));
    send_item(ModePostThread, SigKill, NoSigs);
    send_item(ModePostShared, SigUrg, NoSigs);
    repeat (14) send_item(ModeDequeue, '0, NoSigs);
  endtask

  task automatic test_queue_full();
    set_dispositions(NoSigs, NoSigs);
    send_item(ModePostThread, SigW'(5), NoSigs);
    for (int k = 0; k < QueueSlots; k++)
      send_item(ModePostShared, SigW'($urandom_range(FirstQueuedSignal, NumSignals)), NoSigs);
    send_item(ModePostThread, SigW'(5), NoSigs);
    send_item(ModePostThread, SigW'(6), NoSigs);
    send_item(ModePostShared, SigCont, NoSigs);
    repeat (QueueSlots + 3) send_item(ModeDequeue, '0, NoSigs);
  endtask

  task automatic test_random(input int unsigned n, input logic [MaskW-1:0] ign,
                             input logic [MaskW-1:0] hnd, input int unsigned gap,
                             input int unsigned stall);
    set_dispositions(ign, hnd);
    max_gap = gap;
    stall_pct = stall;
    burst_left = 0;
    repeat (n) random_item();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_dispositions();
    test_queue_full();
    test_random(160, NoSigs, NoSigs, 0, 0);
    test_random(160, NoSigs, NoSigs, 4, 30);
    test_random(160, rand64() & rand64(), rand64(), 2, 0);
    test_random(160, NoSigs, EverySig, 0, 60);
    test_random(140, EverySig, NoSigs, 6, 20);
    test_random(160, rand64(), rand64(), 1, 50);
    test_random(20, NoSigs, NoSigs, 0, 0);
    wait_idle();
    if (err_count == 0) $display("signal_pending_mask_controller_tb: clean");
    else $display("signal_pending_mask_controller_tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("signal_pending_mask_controller_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/spmc_pkg.sv
hw/rtl/spmc_cnt_ram.sv
hw/rtl/spmc_cfg_regs.sv
hw/rtl/signal_pending_mask_controller.sv
verif/signal_pending_mask_controller_tb.sv
